// ===== src/mfhp_pkg.sv =====
// ----------------------------------------------------------------------------
// MAC frame header parser package
// Types, codes and helper functions shared by the header parser modules.
// ----------------------------------------------------------------------------
package mfhp_pkg;

   localparam int MAX_FRAME_BYTES_DEFAULT = 127;

   localparam logic [15:0] BCAST_VALUE     = 16'hFFFF;
   localparam logic [2:0]  DATA_FRAME_TYPE = 3'd1;
   localparam logic [1:0]  MODE_NONE       = 2'd0;
   localparam logic [1:0]  MODE_RESERVED   = 2'd1;
   localparam logic [1:0]  MODE_SHORT      = 2'd2;
   localparam logic [1:0]  MODE_LONG       = 2'd3;
   localparam int          RESERVED_BIT    = 7;

   typedef enum logic [2:0] {
      STATUS_OK           = 3'd0,
      STATUS_RESERVED_BIT = 3'd1,
      STATUS_NOT_DATA     = 3'd2,
      STATUS_BAD_DST_MODE = 3'd3,
      STATUS_BAD_SRC_MODE = 3'd4,
      STATUS_TRUNCATED    = 3'd5,
      STATUS_TOO_LONG     = 3'd6
   } status_type;

   typedef struct packed {
      logic [7:0]  byte_count;
      logic [15:0] frame_control;
      logic [7:0]  seq_reg;
      logic [15:0] pan_reg;
      logic [63:0] dst_reg;
      logic [63:0] src_reg;
      logic        bcast_flag;
      logic [7:0]  hdr_len_reg;
      status_type  error_code;
   } parse_state_type;

   typedef struct packed {
      status_type  status;
      logic [2:0]  frame_type;
      logic [1:0]  dst_mode;
      logic [1:0]  src_mode;
      logic [7:0]  seq_num;
      logic [15:0] pan_id;
      logic [63:0] dest_address;
      logic [63:0] source_address;
      logic        broadcast;
      logic [7:0]  hdr_len;
      logic [7:0]  payload_len;
   } result_type;

   function automatic logic [3:0] mode_len(input logic [1:0] mode);
      logic [3:0] len;
      unique case (mode)
         MODE_SHORT: len = 4'd2;
         MODE_LONG:  len = 4'd8;
         default:    len = 4'd0;
      endcase
      return len;
   endfunction

   // First byte index of the source address field.
   function automatic logic [3:0] src_start(input logic [15:0] fc, input logic bcast);
      logic [3:0] d;
      logic [3:0] e;
      d = mode_len(fc[11:10]);
      e = (d != 4'd0) ? 4'd5 + d : 4'd3;
      return e + (bcast ? 4'd2 : 4'd0);
   endfunction

   function automatic logic [4:0] header_len(input logic [15:0] fc, input logic bcast);
      return {1'b0, src_start(fc, bcast)} + {1'b0, mode_len(fc[15:14])};
   endfunction

endpackage

// ===== src/mac_frame_header_parser_core.sv =====
// ----------------------------------------------------------------------------
// MAC frame header parser core
// Parses the MAC header of a radio data frame presented one byte per
// transfer and reports status, modes, addresses and lengths at the last byte.
//
//   Channel   Direction  Handshake          Payload
//   req_      in         req_valid/stall    data_byte, last_byte
//   rsp_      out        rsp_valid/stall    status ... payload_len
//
// One byte is accepted per cycle while req_stall is low; a byte is held in the
// input register and its result, if any, passes from there into the result
// register. The only stall comes from a last byte whose result cannot yet enter
// a full, stalled result register. Reset is synchronous and clears the parse
// state and both valid flags.
// ----------------------------------------------------------------------------
module mac_frame_header_parser_core #(
   parameter int MAX_FRAME_BYTES = mfhp_pkg::MAX_FRAME_BYTES_DEFAULT
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_stall,
   input  logic [7:0]  req_data_byte,
   input  logic        req_last_byte,
   output logic        rsp_valid,
   input  logic        rsp_stall,
   output logic [2:0]  rsp_status,
   output logic [2:0]  rsp_frame_type,
   output logic [1:0]  rsp_dst_mode,
   output logic [1:0]  rsp_src_mode,
   output logic [7:0]  rsp_seq_num,
   output logic [15:0] rsp_pan_id,
   output logic [63:0] rsp_dest_address,
   output logic [63:0] rsp_source_address,
   output logic        rsp_broadcast,
   output logic [7:0]  rsp_hdr_len,
   output logic [7:0]  rsp_payload_len
);

   logic                 in_valid_ff;
   logic                 in_valid_in;
   logic [7:0]           in_byte_ff;
   logic                 in_last_ff;
   logic                 out_valid_ff;
   logic                 out_valid_in;
   logic                 step;
   logic                 out_load;
   mfhp_pkg::result_type result;
   mfhp_pkg::result_type out_ff;

   assign step      = in_valid_ff && (!in_last_ff || !out_valid_ff || !rsp_stall);
   assign out_load  = step && in_last_ff;
   assign req_stall = in_valid_ff && !step;

   assign in_valid_in  = req_stall ? in_valid_ff : req_valid;
   assign out_valid_in = out_load ? 1'b1 : (rsp_stall ? out_valid_ff : 1'b0);

   mfhp_parser #(
      .MAX_FRAME_BYTES(MAX_FRAME_BYTES)
   ) u_parser (
      .clock     (clock),
      .reset     (reset),
      .step      (step),
      .data_byte (in_byte_ff),
      .last_byte (in_last_ff),
      .result    (result)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff  <= 1'b0;
         out_valid_ff <= 1'b0;
      end else begin
         in_valid_ff  <= in_valid_in;
         out_valid_ff <= out_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (req_valid && !req_stall) begin
         in_byte_ff <= req_data_byte;
         in_last_ff <= req_last_byte;
      end
      if (out_load) begin
         out_ff <= result;
      end
   end

   assign rsp_valid          = out_valid_ff;
   assign rsp_status         = out_ff.status;
   assign rsp_frame_type     = out_ff.frame_type;
   assign rsp_dst_mode       = out_ff.dst_mode;
   assign rsp_src_mode       = out_ff.src_mode;
   assign rsp_seq_num        = out_ff.seq_num;
   assign rsp_pan_id         = out_ff.pan_id;
   assign rsp_dest_address   = out_ff.dest_address;
   assign rsp_source_address = out_ff.source_address;
   assign rsp_broadcast      = out_ff.broadcast;
   assign rsp_hdr_len        = out_ff.hdr_len;
   assign rsp_payload_len    = out_ff.payload_len;

`ifndef SYNTHESIS
   a_stall_cause: assert property (@(posedge clock) disable iff (reset)
      req_stall |-> (in_valid_ff && in_last_ff && out_valid_ff && rsp_stall))
      else $error("Input stalled without a blocked result.");

   a_result_follows: assert property (@(posedge clock) disable iff (reset)
      out_load |=> rsp_valid)
      else $error("Last byte processed but no result presented.");

   a_error_lengths: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_status != mfhp_pkg::STATUS_OK)
      |-> (rsp_hdr_len == 8'd0 && rsp_payload_len == 8'd0))
      else $error("Lengths reported on a failed frame.");

   a_bcast_short: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_broadcast) |-> (rsp_dst_mode == mfhp_pkg::MODE_SHORT))
      else $error("Broadcast reported without a short destination.");
`endif

endmodule

// ===== src/mfhp_parser.sv =====
// ----------------------------------------------------------------------------
// MAC frame header parser state and field capture
// Holds the per-frame parse state, captures each byte by its position and
// forms the result item when the last byte of a frame is processed.
// ----------------------------------------------------------------------------
module mfhp_parser #(
   parameter int MAX_FRAME_BYTES = mfhp_pkg::MAX_FRAME_BYTES_DEFAULT
) (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 step,
   input  logic [7:0]           data_byte,
   input  logic                 last_byte,
   output mfhp_pkg::result_type result
);

   localparam logic [7:0] MAX_INDEX = 8'(MAX_FRAME_BYTES);

   mfhp_pkg::parse_state_type state_ff;
   mfhp_pkg::parse_state_type state_in;
   mfhp_pkg::parse_state_type cap;
   mfhp_pkg::status_type      err;
   mfhp_pkg::status_type      status;

   logic [7:0] idx;
   logic [3:0] d_len;
   logic [3:0] s_cur;
   logic [3:0] s_len;
   logic [7:0] dst_off;
   logic [7:0] src_off;
   logic [3:0] s_new;
   logic [4:0] hdr_new;
   logic [8:0] len;

   assign idx     = state_ff.byte_count;
   assign d_len   = mfhp_pkg::mode_len(state_ff.frame_control[11:10]);
   assign s_len   = mfhp_pkg::mode_len(state_ff.frame_control[15:14]);
   assign s_cur   = mfhp_pkg::src_start(state_ff.frame_control, state_ff.bcast_flag);
   assign dst_off = idx - 8'd5;
   assign src_off = idx - {4'd0, s_cur};
   assign len     = {1'b0, idx} + 9'd1;

   always_comb begin
      cap = state_ff;
      if (state_ff.error_code == mfhp_pkg::STATUS_OK) begin
         if (idx == 8'd0) begin
            cap.frame_control[7:0] = data_byte;
         end else if (idx == 8'd1) begin
            cap.frame_control[15:8] = data_byte;
         end else if (idx == 8'd2) begin
            cap.seq_reg = data_byte;
         end else if (d_len != 4'd0 && idx == 8'd3) begin
            cap.pan_reg[7:0] = data_byte;
         end else if (d_len != 4'd0 && idx == 8'd4) begin
            cap.pan_reg[15:8] = data_byte;
         end else if (d_len != 4'd0 && idx >= 8'd5 && idx < 8'd5 + {4'd0, d_len}) begin
            cap.dst_reg[{dst_off[2:0], 3'b000} +: 8] = data_byte;
            if (d_len == 4'd2 && idx == 8'd6 && state_ff.pan_reg == mfhp_pkg::BCAST_VALUE
                && {data_byte, state_ff.dst_reg[7:0]} == mfhp_pkg::BCAST_VALUE) begin
               cap.bcast_flag = 1'b1;
            end
         end else if (d_len != 4'd0 && state_ff.bcast_flag
                      && idx == 8'd5 + {4'd0, d_len}) begin
            cap.pan_reg[7:0] = data_byte;
         end else if (d_len != 4'd0 && state_ff.bcast_flag
                      && idx == 8'd6 + {4'd0, d_len}) begin
            cap.pan_reg[15:8] = data_byte;
         end else if (idx >= {4'd0, s_cur} && idx < {4'd0, s_cur} + {4'd0, s_len}) begin
            cap.src_reg[{src_off[2:0], 3'b000} +: 8] = data_byte;
         end
      end
   end

   assign s_new   = mfhp_pkg::src_start(cap.frame_control, cap.bcast_flag);
   assign hdr_new = mfhp_pkg::header_len(cap.frame_control, cap.bcast_flag);

   always_comb begin
      err = state_ff.error_code;
      if (state_ff.error_code == mfhp_pkg::STATUS_OK) begin
         if (idx == 8'd1) begin
            if (cap.frame_control[mfhp_pkg::RESERVED_BIT]) begin
               err = mfhp_pkg::STATUS_RESERVED_BIT;
            end else if (cap.frame_control[2:0] != mfhp_pkg::DATA_FRAME_TYPE) begin
               err = mfhp_pkg::STATUS_NOT_DATA;
            end
         end else if (idx == 8'd2 && cap.frame_control[11:10] == mfhp_pkg::MODE_RESERVED) begin
            err = mfhp_pkg::STATUS_BAD_DST_MODE;
         end
         if (err == mfhp_pkg::STATUS_OK && idx >= 8'd2 && len == {5'd0, s_new}
             && cap.frame_control[15:14] == mfhp_pkg::MODE_RESERVED) begin
            err = mfhp_pkg::STATUS_BAD_SRC_MODE;
         end
         if (err == mfhp_pkg::STATUS_OK && idx >= MAX_INDEX) begin
            err = mfhp_pkg::STATUS_TOO_LONG;
         end
      end
   end

   always_comb begin
      status = err;
      if (err == mfhp_pkg::STATUS_OK && len < {4'd0, hdr_new} + 9'd2) begin
         status = mfhp_pkg::STATUS_TRUNCATED;
      end
   end

   always_comb begin
      result.status         = status;
      result.frame_type     = cap.frame_control[2:0];
      result.dst_mode       = cap.frame_control[11:10];
      result.src_mode       = cap.frame_control[15:14];
      result.seq_num        = cap.seq_reg;
      result.pan_id         = cap.pan_reg;
      result.dest_address   = cap.dst_reg;
      result.source_address = cap.src_reg;
      result.broadcast      = cap.bcast_flag;
      if (status == mfhp_pkg::STATUS_OK) begin
         result.hdr_len     = (err == mfhp_pkg::STATUS_OK && idx >= 8'd2)
                              ? {3'd0, hdr_new} : state_ff.hdr_len_reg;
         result.payload_len = 8'(len - {4'd0, hdr_new} - 9'd2);
      end else begin
         result.hdr_len     = 8'd0;
         result.payload_len = 8'd0;
      end
   end

   always_comb begin
      state_in = state_ff;
      if (step) begin
         if (last_byte) begin
            state_in = '0;
         end else begin
            state_in            = cap;
            state_in.error_code = err;
            if (err == mfhp_pkg::STATUS_OK && idx >= 8'd2) begin
               state_in.hdr_len_reg = {3'd0, hdr_new};
            end
            if (idx != 8'hFF) begin
               state_in.byte_count = idx + 8'd1;
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= '0;
      end else begin
         state_ff <= state_in;
      end
   end

endmodule
